[hdl/ieu_pkg.sv]
// Package for the integer execute unit: opcodes, store sizes, masks and the
// transaction payload types shared by the interfaces, the execute logic and the top.
// No dependencies.
package ieu_pkg;

	localparam int unsigned PC_BITS_DEF  = 32;
	localparam int unsigned NUM_REGS_DEF = 32;
	localparam int unsigned XLEN         = 64;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_SUB   = 5'd1,
		OP_SLL   = 5'd2,
		OP_SLT   = 5'd3,
		OP_SLTU  = 5'd4,
		OP_XOR   = 5'd5,
		OP_SRL   = 5'd6,
		OP_SRA   = 5'd7,
		OP_OR    = 5'd8,
		OP_AND   = 5'd9,
		OP_LUI   = 5'd10,
		OP_AUIPC = 5'd11,
		OP_BEQ   = 5'd12,
		OP_BNE   = 5'd13,
		OP_BLT   = 5'd14,
		OP_BGE   = 5'd15,
		OP_BLTU  = 5'd16,
		OP_BGEU  = 5'd17,
		OP_JAL   = 5'd18,
		OP_JALR  = 5'd19,
		OP_SB    = 5'd20,
		OP_SH    = 5'd21,
		OP_SW    = 5'd22
	} op_t;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [XLEN-1:0] UPPER_MASK = 64'hFFFF_FFFF_FF00_0000;
	localparam logic [XLEN-1:0] BYTE_MASK  = 64'h0000_0000_0000_00FF;
	localparam logic [XLEN-1:0] HALF_MASK  = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [4:0]             op;
		logic                   use_imm;
		logic [4:0]             rd;
		logic [4:0]             rs1;
		logic [4:0]             rs2;
		logic signed [XLEN-1:0] imm;
		logic [31:0]            target;
	} instr_t;

	typedef struct packed {
		logic            rd_write;
		logic [4:0]      rd_index;
		logic [XLEN-1:0] rd_value;
		logic [31:0]     next_pc;
		logic            mem_write;
		logic [XLEN-1:0] mem_addr;
		logic [XLEN-1:0] mem_data;
		logic [1:0]      mem_size;
	} result_t;

endpackage

[hdl/ieu_stream_if.sv]
// Valid/ready stream interface used for the instruction and result channels.
// Payload type is a parameter; the unit uses ieu_pkg::instr_t and ieu_pkg::result_t.
interface ieu_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ieu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the register file copies.
module ieu_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/ieu_exec.sv]
// Execute logic: ALU, branch compare, jump and store formation for one instruction.
// Depends on ieu_pkg. Purely combinational.
module ieu_exec
	import ieu_pkg::*;
#(
	parameter int unsigned PC_BITS  = PC_BITS_DEF,
	parameter int unsigned NUM_REGS = NUM_REGS_DEF
) (
	input  instr_t             instr,
	input  logic [XLEN-1:0]    a,
	input  logic [XLEN-1:0]    b_reg,
	input  logic [PC_BITS-1:0] pc,
	output logic [PC_BITS-1:0] pc_next,
	output result_t            res
);

	logic [XLEN-1:0] b;
	logic [5:0]      sh;
	logic [XLEN-1:0] pc_ext;
	logic [XLEN-1:0] pc_inc;
	logic [XLEN-1:0] addr_sum;
	logic            wr;
	logic            taken;
	logic [XLEN-1:0] val;
	logic [XLEN-1:0] next_ext;

	assign b        = instr.use_imm ? instr.imm : b_reg;
	assign sh       = b[5:0];
	assign pc_ext   = XLEN'(pc);
	assign pc_inc   = pc_ext + XLEN'(1);
	assign addr_sum = a + instr.imm;

	always_comb begin
		wr            = 1'b0;
		taken         = 1'b0;
		val           = '0;
		next_ext      = pc_inc;
		res.mem_write = 1'b0;
		res.mem_addr  = '0;
		res.mem_data  = '0;
		res.mem_size  = SIZE_BYTE;
		unique case (instr.op)
			OP_ADD:   begin wr = 1'b1; val = a + b; end
			OP_SUB:   begin wr = 1'b1; val = a - b; end
			OP_SLL:   begin wr = 1'b1; val = a << sh; end
			OP_SLT:   begin wr = 1'b1; val = XLEN'($signed(a) < $signed(b)); end
			OP_SLTU:  begin wr = 1'b1; val = XLEN'(a < b); end
			OP_XOR:   begin wr = 1'b1; val = a ^ b; end
			OP_SRL:   begin wr = 1'b1; val = a >> sh; end
			OP_SRA:   begin wr = 1'b1; val = $unsigned($signed(a) >>> sh); end
			OP_OR:    begin wr = 1'b1; val = a | b; end
			OP_AND:   begin wr = 1'b1; val = a & b; end
			OP_LUI:   begin wr = 1'b1; val = instr.imm & UPPER_MASK; end
			OP_AUIPC: begin wr = 1'b1; val = pc_ext + (instr.imm & UPPER_MASK); end
			OP_BEQ:   taken = (a == b_reg);
			OP_BNE:   taken = (a != b_reg);
			OP_BLT:   taken = ($signed(a) < $signed(b_reg));
			OP_BGE:   taken = !($signed(a) < $signed(b_reg));
			OP_BLTU:  taken = (a < b_reg);
			OP_BGEU:  taken = (a >= b_reg);
			OP_JAL: begin
				wr       = 1'b1;
				val      = pc_inc;
				next_ext = XLEN'(instr.target);
			end
			OP_JALR: begin
				wr       = 1'b1;
				val      = pc_inc;
				next_ext = addr_sum;
			end
			OP_SB: begin
				res.mem_write = 1'b1;
				res.mem_addr  = addr_sum;
				res.mem_data  = b_reg & BYTE_MASK;
				res.mem_size  = SIZE_BYTE;
			end
			OP_SH: begin
				res.mem_write = 1'b1;
				res.mem_addr  = addr_sum;
				res.mem_data  = b_reg & HALF_MASK;
				res.mem_size  = SIZE_HALF;
			end
			OP_SW: begin
				res.mem_write = 1'b1;
				res.mem_addr  = addr_sum;
				res.mem_data  = b_reg;
				res.mem_size  = SIZE_WORD;
			end
			default: ;
		endcase
		if (taken) begin
			next_ext = XLEN'(instr.target);
		end
		// x0 and registers past the file size swallow writes
		if (instr.rd == '0 || 32'(instr.rd) >= NUM_REGS) begin
			wr = 1'b0;
		end
		res.rd_write = wr;
		res.rd_index = wr ? instr.rd : '0;
		res.rd_value = wr ? val : '0;
		pc_next      = PC_BITS'(next_ext);
		res.next_pc  = 32'(pc_next);
	end

endmodule

[hdl/integer_execute_unit_core.sv]
// Channel  | dir | payload   | transaction when
// instr    | in  | instr_t   | instr.valid && instr.ready
// result   | out | result_t  | result.valid && result.ready
//
// One instruction per cycle: operands are read from the register file RAMs
// into the issue stage (_s1), executed there, and the result lands in the
// output register (_s2). Register file and PC update as an instruction leaves
// _s1; a write in that cycle is forwarded to the instruction entering _s1.
// Reset clears the PC and the per-register valid bits (unwritten registers
// read as zero); no clearing pass. A stalled result register holds _s1, and
// the unit still takes a new instruction whenever _s1 is empty or moving.
// Depends on ieu_pkg, ieu_stream_if, ieu_ram, ieu_exec.
module integer_execute_unit_core
	import ieu_pkg::*;
#(
	parameter int unsigned PC_BITS  = PC_BITS_DEF,
	parameter int unsigned NUM_REGS = NUM_REGS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ieu_stream_if.sink    instr,
	ieu_stream_if.source  result
);

	localparam int unsigned AW = $clog2(NUM_REGS);

	instr_t             instr_s1;
	logic               valid_s1;
	logic               fwd_a_s1;
	logic               fwd_b_s1;
	logic               src_a_s1;
	logic               src_b_s1;
	logic [XLEN-1:0]    fwd_val_s1;
	result_t            res_s2;
	logic               valid_s2;
	logic [PC_BITS-1:0] pc_q;
	logic [NUM_REGS-1:0] vld_q;

	logic               accept;
	logic               advance;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [XLEN-1:0]    ram_a;
	logic [XLEN-1:0]    ram_b;
	logic [XLEN-1:0]    opnd_a;
	logic [XLEN-1:0]    opnd_b;
	logic [PC_BITS-1:0] pc_next;
	result_t            ex_res;
	logic               hit_a;
	logic               hit_b;
	logic               rd_ok_a;
	logic               rd_ok_b;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready  = !valid_s1 || advance;
	assign accept       = instr.valid && instr.ready;
	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	assign we    = advance && ex_res.rd_write;
	assign waddr = ex_res.rd_index[AW-1:0];

	// forward the write retiring this cycle to the instruction being issued
	assign hit_a = we && (ex_res.rd_index == instr.data.rs1);
	assign hit_b = we && (ex_res.rd_index == instr.data.rs2);

	assign rd_ok_a = instr.data.rs1 != '0 && 32'(instr.data.rs1) < NUM_REGS &&
		vld_q[instr.data.rs1[AW-1:0]];
	assign rd_ok_b = instr.data.rs2 != '0 && 32'(instr.data.rs2) < NUM_REGS &&
		vld_q[instr.data.rs2[AW-1:0]];

	ieu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ex_res.rd_value),
		.re    (accept),
		.raddr (instr.data.rs1[AW-1:0]),
		.rdata (ram_a)
	);

	ieu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ex_res.rd_value),
		.re    (accept),
		.raddr (instr.data.rs2[AW-1:0]),
		.rdata (ram_b)
	);

	assign opnd_a = fwd_a_s1 ? fwd_val_s1 : (src_a_s1 ? ram_a : '0);
	assign opnd_b = fwd_b_s1 ? fwd_val_s1 : (src_b_s1 ? ram_b : '0);

	ieu_exec #(.PC_BITS(PC_BITS), .NUM_REGS(NUM_REGS)) u_exec (
		.instr   (instr_s1),
		.a       (opnd_a),
		.b_reg   (opnd_b),
		.pc      (pc_q),
		.pc_next (pc_next),
		.res     (ex_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= '0;
			vld_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				pc_q     <= pc_next;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1   <= instr.data;
			fwd_a_s1   <= hit_a;
			fwd_b_s1   <= hit_b;
			src_a_s1   <= rd_ok_a;
			src_b_s1   <= rd_ok_b;
			fwd_val_s1 <= ex_res.rd_value;
		end
		if (advance) begin
			res_s2 <= ex_res;
		end
	end

	a_pc_moves_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pc_q))
		else $error("PC changed without a retiring instruction");

	a_x0_never_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0])
		else $error("register x0 marked as written");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> valid_s1 && valid_s2 && !result.ready)
		else $error("instruction channel stalled with room in the pipe");

	a_write_or_store: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.data.rd_write && result.data.mem_write))
		else $error("result carries both a register write and a store");

endmodule
